// File: hdl/assert_macros.svh
// Assertion macros used by the first-touch renumbering sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Flag any cycle in which cond holds.
`define FTR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Require post in the same cycle as pre.
`define FTR_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`else

`define FTR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define FTR_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// File: hdl/ftr_pkg.sv
// Types and constants shared by the first-touch renumbering modules.
package ftr_pkg;

    localparam int MAX_ITEMS_DEF = 1024;

    localparam int IDX_W    = 10;
    localparam int SIZE_W   = 11;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_TOUCH   = 2'd0,
        CMD_FLUSH   = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MAPPED = 2'd0,
        ST_DONE   = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef struct packed {
        logic [IDX_W-1:0] old_index;
        logic [IDX_W-1:0] new_index;
        status_t          status;
    } result_t;

endpackage

// File: hdl/ftr_bitmap_ram.sv
// Taken bitmap: one-bit synchronous memory with one write and one registered read port.
module ftr_bitmap_ram #(
    parameter int DEPTH = ftr_pkg::MAX_ITEMS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem_reg [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        // hold read data while no read is issued
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/ftr_out_stage.sv
// Output register for result beats on the valid/stall channel.
module ftr_out_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_push,
    input  ftr_pkg::result_t               res,
    output logic                           slot_free,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ftr_pkg::IDX_W-1:0]      old_index,
    output logic [ftr_pkg::IDX_W-1:0]      new_index,
    output logic [ftr_pkg::STATUS_W-1:0]   status
);

    logic             out_valid_reg;
    logic             out_valid_next;
    ftr_pkg::result_t data_reg;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (res_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign old_index = data_reg.old_index;
    assign new_index = data_reg.new_index;
    assign status    = data_reg.status;

endmodule

// File: hdl/ftr_ctrl.sv
// Sequencer: clear pass, touch read-modify-write, flush walk and counters.
`include "assert_macros.svh"

module ftr_ctrl #(
    parameter int MAX_ITEMS = ftr_pkg::MAX_ITEMS_DEF,
    localparam int AW = $clog2(MAX_ITEMS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ftr_pkg::SIZE_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ftr_pkg::CMD_W-1:0]     cmd,
    input  logic [ftr_pkg::IDX_W-1:0]     item_index,
    output logic                          res_push,
    output ftr_pkg::result_t              res,
    input  logic                          slot_free,
    output logic                          mem_wr_en,
    output logic [AW-1:0]                 mem_wr_addr,
    output logic                          mem_wr_data,
    output logic                          mem_rd_en,
    output logic [AW-1:0]                 mem_rd_addr,
    input  logic                          mem_rd_data
);

    localparam int PW  = AW + 1;
    localparam int CW0 = (PW > ftr_pkg::SIZE_W) ? PW : ftr_pkg::SIZE_W;
    localparam int CW  = (CW0 > ftr_pkg::IDX_W) ? CW0 : ftr_pkg::IDX_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ITEMS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_TOUCH = 5'b00100,
        S_SCAN  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [ftr_pkg::SIZE_W-1:0] size_reg;
    logic [PW-1:0]              scan_pos_reg;
    logic [PW-1:0]              scan_pos_next;
    logic [PW-1:0]              next_id_reg;
    logic [PW-1:0]              next_id_next;
    logic [AW-1:0]              clr_addr_reg;
    logic [AW-1:0]              clr_addr_next;
    logic [AW-1:0]              idx_reg;
    logic [AW-1:0]              idx_next;
    ftr_pkg::result_t           pend_reg;
    ftr_pkg::result_t           pend_next;
    logic [PW-1:0]              size_eff;
    logic [PW-1:0]              scan_inc;

    always_comb
    begin
        if (CW'(size_reg) > CW'(MAX_ITEMS))
        begin
            size_eff = PW'(MAX_ITEMS);
        end
        else
        begin
            size_eff = PW'(size_reg);
        end
    end

    assign scan_inc = scan_pos_reg + PW'(1);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        scan_pos_next = scan_pos_reg;
        next_id_next  = next_id_reg;
        clr_addr_next = clr_addr_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = clr_addr_reg;
        mem_wr_data   = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = idx_reg;
        res_push      = 1'b0;
        res           = pend_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = 1'b0;
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd)
                        ftr_pkg::CMD_TOUCH:
                        begin
                            if (CW'(item_index) >= CW'(size_eff))
                            begin
                                pend_next.old_index = item_index;
                                pend_next.new_index = '0;
                                pend_next.status    = ftr_pkg::ST_RANGE;
                                state_next          = S_EMIT;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(item_index);
                                idx_next    = AW'(item_index);
                                state_next  = S_TOUCH;
                            end
                        end

                        ftr_pkg::CMD_FLUSH:
                        begin
                            if (scan_pos_reg >= size_eff)
                            begin
                                scan_pos_next       = size_eff;
                                pend_next.old_index = '0;
                                pend_next.new_index = '0;
                                pend_next.status    = ftr_pkg::ST_DONE;
                                state_next          = S_EMIT;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = scan_pos_reg[AW-1:0];
                                state_next  = S_SCAN;
                            end
                        end

                        ftr_pkg::CMD_RESTART:
                        begin
                            next_id_next  = '0;
                            scan_pos_next = '0;
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end

                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_TOUCH:
            begin
                if (mem_rd_data)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    mem_wr_en     = 1'b1;
                    mem_wr_addr   = idx_reg;
                    mem_wr_data   = 1'b1;
                    res_push      = 1'b1;
                    res.old_index = ftr_pkg::IDX_W'(idx_reg);
                    res.new_index = ftr_pkg::IDX_W'(next_id_reg);
                    res.status    = ftr_pkg::ST_MAPPED;
                    next_id_next  = next_id_reg + PW'(1);
                    state_next    = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (!mem_rd_data)
                begin
                    if (slot_free)
                    begin
                        mem_wr_en     = 1'b1;
                        mem_wr_addr   = scan_pos_reg[AW-1:0];
                        mem_wr_data   = 1'b1;
                        res_push      = 1'b1;
                        res.old_index = ftr_pkg::IDX_W'(scan_pos_reg);
                        res.new_index = ftr_pkg::IDX_W'(next_id_reg);
                        res.status    = ftr_pkg::ST_MAPPED;
                        next_id_next  = next_id_reg + PW'(1);
                        scan_pos_next = scan_inc;
                        state_next    = S_IDLE;
                    end
                end
                else if (scan_inc >= size_eff)
                begin
                    scan_pos_next       = scan_inc;
                    pend_next.old_index = '0;
                    pend_next.new_index = '0;
                    pend_next.status    = ftr_pkg::ST_DONE;
                    state_next          = S_EMIT;
                end
                else
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = scan_inc[AW-1:0];
                    scan_pos_next = scan_inc;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    res_push   = 1'b1;
                    res        = pend_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            size_reg     <= ftr_pkg::SIZE_RESET;
            scan_pos_reg <= '0;
            next_id_reg  <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_pos_reg <= scan_pos_next;
            next_id_reg  <= next_id_next;
            clr_addr_reg <= clr_addr_next;
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
    end

    `FTR_ASSERT_NEVER(a_no_rd_wr_overlap, clk, rst_n, mem_wr_en && mem_rd_en, "bitmap read and write in one cycle")
    `FTR_ASSERT_IMPLY(a_push_needs_slot, clk, rst_n, res_push, slot_free, "result beat pushed into a full output register")
    `FTR_ASSERT_IMPLY(a_clear_covers_all, clk, rst_n, (state_reg == S_CLEAR) && (state_next != S_CLEAR), clr_addr_reg == CLR_LAST, "clear pass left early")
    `FTR_ASSERT_NEVER(a_next_id_bound, clk, rst_n, next_id_reg > PW'(MAX_ITEMS), "new id count beyond map depth")

endmodule

// File: hdl/first_touch_renumbering.sv
// First-touch renumbering top level: sequencer, taken bitmap memory and output register.
// Touch: TOUCH pushes a beat after the bitmap read; a repeated touch gives no beat.
// Flush: one bitmap read per cycle while the walk skips taken entries.
// Out-of-range touch and flush already done: EMIT pushes the beat once the slot is free.
// A new command is accepted only in idle; output stalls hold the sequencer out of idle.
// Reset and restart run a clearing pass over every bitmap entry with input stalled.
module first_touch_renumbering #(
    parameter int MAX_ITEMS = ftr_pkg::MAX_ITEMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ftr_pkg::SIZE_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ftr_pkg::CMD_W-1:0]     cmd,
    input  logic [ftr_pkg::IDX_W-1:0]     item_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ftr_pkg::IDX_W-1:0]     old_index,
    output logic [ftr_pkg::IDX_W-1:0]     new_index,
    output logic [ftr_pkg::STATUS_W-1:0]  status
);

    localparam int AW = $clog2(MAX_ITEMS);

    logic             res_push;
    ftr_pkg::result_t res;
    logic             slot_free;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic             mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic             mem_rd_data;

    ftr_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .item_index  (item_index),
        .res_push    (res_push),
        .res         (res),
        .slot_free   (slot_free),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    ftr_bitmap_ram #(
        .DEPTH (MAX_ITEMS)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ftr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .old_index (old_index),
        .new_index (new_index),
        .status    (status)
    );

endmodule
